// ===== design/stroke_dab_interpolator_defines.svh =====
// Assertion macros for the stroke dab interpolator.
// Used by the modules that check their own control logic; needs clk and arst_n in scope.
`ifndef STROKE_DAB_INTERPOLATOR_DEFINES_SVH
`define STROKE_DAB_INTERPOLATOR_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define SDI_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define SDI_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SDI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/sdi_pkg.sv =====
// Shared types, widths and codes for the stroke dab interpolator.
// No dependencies; imported by every module of the block.
`default_nettype none

package sdi_pkg;

	// field widths
	localparam int POS_W     = 21;
	localparam int PRES_IN_W = 10;
	localparam int PRES_W    = 9;
	localparam int BOX_W     = 14;
	localparam int RAD_W     = 16;
	localparam int CMD_W     = 3;
	localparam int KIND_W    = 2;

	// parameter defaults
	localparam int TILE_SIZE_DEF     = 8;
	localparam int PENDING_LIMIT_DEF = 64;

	// datapath widths
	localparam int DIFF_W    = POS_W + 1;
	localparam int MAG_W     = POS_W;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int RAD_SUM_W = SQ_W + 2;
	localparam int DIST_W    = RAD_SUM_W / 2;
	localparam int SP_W      = 15;
	localparam int NUM_W     = MAG_W + SP_W;
	localparam int T_W       = DIST_W + 1;
	localparam int U_W       = 14;
	localparam int RECIP_SHIFT = 21;

	// spacing = max(radius * 90 / 256, 1 voxel)
	localparam logic [6:0]      SP_MULT = 7'd90;
	localparam logic [SP_W-1:0] SP_MIN  = 15'd256;
	localparam logic [RAD_W-1:0] RAD_RESET = 16'd256;
	localparam logic [PRES_W-1:0] PRES_ONE = 9'd256;

	// command codes
	localparam logic [CMD_W-1:0] CMD_BEGIN  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SAMPLE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_END    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RESET  = 3'd4;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BOX   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DAB   = 2'd2;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_BEGIN,
		OP_SAMPLE,
		OP_END,
		OP_CLEAR,
		OP_RESET
	} op_t;

	typedef struct packed {
		op_t                      op;
		logic signed [POS_W-1:0]  x;
		logic signed [POS_W-1:0]  y;
		logic signed [POS_W-1:0]  z;
		logic [PRES_W-1:0]        pres;
	} item_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_req_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SUB,
		S_SQ,
		S_SUM,
		S_ROOT,
		S_CHECK,
		S_DIV,
		S_STEP,
		S_BOX1,
		S_BOX2,
		S_BOX3,
		S_LOAD,
		S_EMIT
	} bk_state_t;

endpackage

`default_nettype wire

// ===== design/sdi_front.sv =====
// Front end: accepts requests, decodes the command, clamps pressure, queues them.
// Depends on sdi_pkg.
`default_nettype none

module sdi_front import sdi_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [CMD_W-1:0]            cmd,
	input  wire logic signed [POS_W-1:0]     pos_x,
	input  wire logic signed [POS_W-1:0]     pos_y,
	input  wire logic signed [POS_W-1:0]     pos_z,
	input  wire logic signed [PRES_IN_W-1:0] pen_pressure,
	output q_req_t                           q_req,
	input  wire logic                        q_ready
);

	item_t      fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	item_t      item_in;
	logic       push;
	logic       pop;

	// classify the request
	always_comb begin
		case (cmd)
			CMD_BEGIN:  item_in.op = OP_BEGIN;
			CMD_SAMPLE: item_in.op = OP_SAMPLE;
			CMD_END:    item_in.op = OP_END;
			CMD_CLEAR:  item_in.op = OP_CLEAR;
			CMD_RESET:  item_in.op = OP_RESET;
			default:    item_in.op = OP_NOP;
		endcase
		item_in.x = pos_x;
		item_in.y = pos_y;
		item_in.z = pos_z;
		if (pen_pressure < 0) begin
			item_in.pres = '0;
		end else if (pen_pressure > $signed({1'b0, PRES_ONE})) begin
			item_in.pres = PRES_ONE;
		end else begin
			item_in.pres = pen_pressure[PRES_W-1:0];
		end
	end

	assign in_ready    = (count_q != 2'd2);
	assign push        = in_valid && in_ready;
	assign q_req.valid = (count_q != 2'd0);
	assign q_req.item  = fifo_q[rd_ptr_q];
	assign pop         = q_req.valid && q_ready;

	// two-entry queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= item_in;
	end

endmodule

`default_nettype wire

// ===== design/sdi_isqrt.sv =====
// Integer square root, two radicand bits per cycle.
// Depends on sdi_pkg for the default width.
`default_nettype none

module sdi_isqrt import sdi_pkg::*; #(
	parameter int RW = RAD_SUM_W
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [RW-1:0]   rad,
	output logic                 done,
	output logic [RW/2-1:0]      root
);

	localparam int OW = RW / 2;
	localparam int CW = $clog2(OW + 1);

	logic [RW-1:0]   rad_q;
	logic [OW+1:0]   rem_q;
	logic [OW-1:0]   root_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [OW+3:0]   rem_sh;
	logic [OW+1:0]   trial;
	logic            ge;
	logic [OW+3:0]   rem_nx;

	// one digit: try root*4+1 against the running remainder
	always_comb begin
		rem_sh = {rem_q, rad_q[RW-1:RW-2]};
		trial  = {root_q, 2'b01};
		ge     = (rem_sh >= {2'b00, trial});
		rem_nx = ge ? (rem_sh - {2'b00, trial}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(OW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RW-3:0], 2'b00};
			rem_q  <= rem_nx[OW+1:0];
			root_q <= {root_q[OW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

// ===== design/sdi_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sdi_pkg for the default widths.
`default_nettype none

module sdi_div import sdi_pkg::*; #(
	parameter int NW = NUM_W,
	parameter int DW = DIST_W
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [NW-1:0]      quot,
	output logic [DW-1:0]      rem
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] n_q;
	logic [DW-1:0] d_q;
	logic [DW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   rem_sh;
	logic          ge;
	logic [DW:0]   rem_nx;

	always_comb begin
		rem_sh = {rem_q, n_q[NW-1]};
		ge     = (rem_sh >= {1'b0, d_q});
		rem_nx = ge ? (rem_sh - {1'b0, d_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// numerator shifts out on top, quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			d_q   <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			n_q   <= {n_q[NW-2:0], ge};
			rem_q <= rem_nx[DW-1:0];
		end
	end

	assign done = done_q;
	assign quot = n_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ===== design/sdi_back.sv =====
// Back end: stroke state, segment length, dab stepping, dirty box and result register.
// Depends on sdi_pkg, sdi_isqrt, sdi_div and the assertion macro header.
`default_nettype none
`include "stroke_dab_interpolator_defines.svh"

module sdi_back import sdi_pkg::*; #(
	parameter int TILE_SIZE     = TILE_SIZE_DEF,
	parameter int PENDING_LIMIT = PENDING_LIMIT_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire q_req_t                  q_req,
	output logic                         q_ready,
	input  wire logic [RAD_W-1:0]        brush_radius,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [KIND_W-1:0]            kind,
	output logic signed [POS_W-1:0]      dab_x,
	output logic signed [POS_W-1:0]      dab_y,
	output logic signed [POS_W-1:0]      dab_z,
	output logic [PRES_W-1:0]            dab_pressure,
	output logic                         last,
	output logic signed [BOX_W-1:0]      box_min_x,
	output logic signed [BOX_W-1:0]      box_min_y,
	output logic signed [BOX_W-1:0]      box_min_z,
	output logic signed [BOX_W-1:0]      box_max_x,
	output logic signed [BOX_W-1:0]      box_max_y,
	output logic signed [BOX_W-1:0]      box_max_z
);

	localparam int PC_W    = $clog2(PENDING_LIMIT + 1);
	localparam int RECIP   = ((1 << RECIP_SHIFT) + TILE_SIZE - 1) / TILE_SIZE;
	localparam int RECIP_W = RECIP_SHIFT + 1;
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
	localparam logic [U_W-1:0]     TS_C    = U_W'(TILE_SIZE);
	localparam logic [U_W-1:0]     TS_M1   = U_W'(TILE_SIZE - 1);
	localparam logic [PC_W:0]      LIMIT_C = (PC_W + 1)'(PENDING_LIMIT);

	bk_state_t state_q, state_d;

	// stroke control state
	logic                    active_q;
	logic                    havep_q;
	logic [PC_W-1:0]         pend_q;
	logic                    box_empty_q;
	logic [RAD_W-1:0]        srad_q;

	// payload state
	logic signed [POS_W-1:0]  cur_q   [3];
	logic signed [POS_W-1:0]  prev_q  [3];
	logic signed [POS_W-1:0]  pos_q   [3];
	logic signed [DIFF_W-1:0] d_q     [3];
	logic [MAG_W-1:0]         mag_q   [3];
	logic [SQ_W-1:0]          sq_q    [3];
	logic [DIST_W-1:0]        acc_q   [3];
	logic [DIST_W-1:0]        rem_q   [3];
	logic [SP_W-1:0]          q0_q    [3];
	logic [DIST_W-1:0]        r0_q    [3];
	logic signed [BOX_W-1:0]  box_q   [6];
	logic [U_W-1:0]           u_q     [6];
	logic [U_W-1:0]           tq_q    [6];
	logic                     neg_q   [6];
	logic [PRES_W-1:0]        pres_q;
	logic [DIST_W-1:0]        dist_q;
	logic [SP_W-1:0]          sp_q;
	logic [T_W-1:0]           t_q;
	logic                     last_q;
	logic                     is_dab_q;

	// result register
	logic [KIND_W-1:0]        kind_q;
	logic signed [POS_W-1:0]  odab_q  [3];
	logic [PRES_W-1:0]        opres_q;
	logic                     olast_q;
	logic signed [BOX_W-1:0]  obox_q  [6];

	// unit handshakes
	logic                     sqrt_start;
	logic                     sqrt_done;
	logic [DIST_W-1:0]        sqrt_root;
	logic                     div_start;
	logic                     div_done    [3];
	logic [NUM_W-1:0]         div_quot    [3];
	logic [DIST_W-1:0]        div_rem     [3];
	logic [NUM_W-1:0]         div_num     [3];

	// combinational helpers
	logic [22:0]              sp_prod;
	logic [SP_W-1:0]          sp_raw;
	logic [SP_W-1:0]          sp_val;
	logic [RAD_SUM_W-1:0]     sq_sum;
	logic                     dist_ok;
	logic                     pend_room;
	logic                     op_first_dab;
	logic [T_W-1:0]           t_nx;
	logic                     more;
	logic [PC_W:0]            pend_inc;
	logic signed [DIFF_W-1:0] d_nx    [3];
	logic [DIST_W:0]          r_sum   [3];
	logic                     wrap    [3];
	logic [DIST_W-1:0]        acc_nx  [3];
	logic [DIST_W-1:0]        rem_nx  [3];
	logic signed [DIST_W:0]   off     [3];
	logic signed [DIST_W:0]   pos_nx  [3];
	logic signed [POS_W+1:0]  a_lo    [3];
	logic signed [POS_W+1:0]  a_hi    [3];
	logic signed [POS_W+1:0]  v_lo    [3];
	logic signed [POS_W+1:0]  w_hi    [3];
	logic [U_W+RECIP_W-1:0]   rprod   [6];
	logic [2*U_W-1:0]         tprod   [6];
	logic signed [BOX_W-1:0]  bval    [6];

	// spacing from the latched stroke radius
	always_comb begin
		sp_prod = 23'(srad_q) * 23'(SP_MULT);
		sp_raw  = sp_prod[22:8];
		sp_val  = (sp_raw < SP_MIN) ? SP_MIN : sp_raw;
	end

	assign sq_sum    = RAD_SUM_W'(sq_q[0]) + RAD_SUM_W'(sq_q[1]) + RAD_SUM_W'(sq_q[2]);
	assign dist_ok   = (dist_q >= DIST_W'(sp_q));
	assign pend_room = ({1'b0, pend_q} < LIMIT_C);
	assign pend_inc  = {1'b0, pend_q} + (PC_W + 1)'(1);
	assign op_first_dab = active_q && !havep_q && pend_room;

	// step the rounded offsets: acc*dist + rem tracks |d|*t + dist/2
	always_comb begin
		t_nx = t_q + T_W'(sp_q);
		more = (t_nx <= T_W'(dist_q)) && (pend_inc < LIMIT_C);
		for (int i = 0; i < 3; i++) begin
			d_nx[i]   = DIFF_W'(cur_q[i]) - DIFF_W'(prev_q[i]);
			r_sum[i]  = {1'b0, rem_q[i]} + {1'b0, r0_q[i]};
			wrap[i]   = (r_sum[i] >= {1'b0, dist_q});
			rem_nx[i] = wrap[i] ? DIST_W'(r_sum[i] - {1'b0, dist_q}) : r_sum[i][DIST_W-1:0];
			acc_nx[i] = acc_q[i] + DIST_W'(q0_q[i]) + DIST_W'(wrap[i]);
			off[i]    = d_q[i][DIFF_W-1] ? -$signed({1'b0, acc_nx[i]}) : $signed({1'b0, acc_nx[i]});
			pos_nx[i] = $signed((DIST_W + 1)'(prev_q[i])) + off[i];
			div_num[i] = NUM_W'(mag_q[i]) * NUM_W'(sp_q);
		end
	end

	// box bounds in whole voxels, then magnitudes for the tile division
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a_lo[i] = (POS_W + 2)'(pos_q[i]) - $signed({7'd0, srad_q});
			a_hi[i] = (POS_W + 2)'(pos_q[i]) + $signed({7'd0, srad_q}) + (POS_W + 2)'(255);
			v_lo[i] = a_lo[i] >>> 8;
			w_hi[i] = a_hi[i] >>> 8;
		end
		for (int j = 0; j < 6; j++) begin
			rprod[j] = (U_W + RECIP_W)'(u_q[j]) * (U_W + RECIP_W)'(RECIP_C);
			tprod[j] = (2 * U_W)'(tq_q[j]) * (2 * U_W)'(TS_C);
			bval[j]  = neg_q[j] ? -$signed(tprod[j][BOX_W-1:0]) : $signed(tprod[j][BOX_W-1:0]);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (q_req.valid) begin
					if (q_req.item.op == OP_SAMPLE && active_q && havep_q) begin
						state_d = S_SUB;
					end else if (q_req.item.op == OP_SAMPLE && op_first_dab) begin
						state_d = S_BOX1;
					end else begin
						state_d = S_LOAD;
					end
				end
			end
			S_SUB:   state_d = S_SQ;
			S_SQ:    state_d = S_SUM;
			S_SUM:   state_d = S_ROOT;
			S_ROOT:  if (sqrt_done) state_d = S_CHECK;
			S_CHECK: state_d = dist_ok ? S_DIV : S_LOAD;
			S_DIV:   if (div_done[0]) state_d = pend_room ? S_STEP : S_LOAD;
			S_STEP:  state_d = S_BOX1;
			S_BOX1:  state_d = S_BOX2;
			S_BOX2:  state_d = S_BOX3;
			S_BOX3:  state_d = S_LOAD;
			S_LOAD:  state_d = S_EMIT;
			S_EMIT:  if (out_ready) state_d = olast_q ? S_IDLE : S_STEP;
			default: state_d = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		q_ready    = (state_q == S_IDLE);
		sqrt_start = (state_q == S_SUM);
		div_start  = (state_q == S_CHECK) && dist_ok;
		out_valid  = (state_q == S_EMIT);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			active_q    <= 1'b0;
			havep_q     <= 1'b0;
			pend_q      <= '0;
			box_empty_q <= 1'b1;
			srad_q      <= RAD_RESET;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && q_req.valid) begin
				case (q_req.item.op)
					OP_BEGIN: begin
						srad_q      <= brush_radius;
						active_q    <= 1'b1;
						havep_q     <= 1'b0;
						pend_q      <= '0;
						box_empty_q <= 1'b1;
					end
					OP_SAMPLE: begin
						if (active_q && !havep_q) begin
							havep_q <= 1'b1;
							if (pend_room) pend_q <= pend_inc[PC_W-1:0];
						end
					end
					OP_END: begin
						active_q <= 1'b0;
						havep_q  <= 1'b0;
					end
					OP_CLEAR: begin
						pend_q      <= '0;
						box_empty_q <= 1'b1;
					end
					OP_RESET: begin
						active_q    <= 1'b0;
						havep_q     <= 1'b0;
						pend_q      <= '0;
						box_empty_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			if (state_q == S_STEP) pend_q <= pend_inc[PC_W-1:0];
			if (state_q == S_BOX3) box_empty_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_req.valid) begin
					cur_q[0] <= q_req.item.x;
					cur_q[1] <= q_req.item.y;
					cur_q[2] <= q_req.item.z;
					pres_q   <= q_req.item.pres;
					last_q   <= 1'b1;
					is_dab_q <= 1'b0;
					if (q_req.item.op == OP_SAMPLE && active_q && !havep_q) begin
						prev_q[0] <= q_req.item.x;
						prev_q[1] <= q_req.item.y;
						prev_q[2] <= q_req.item.z;
						pos_q[0]  <= q_req.item.x;
						pos_q[1]  <= q_req.item.y;
						pos_q[2]  <= q_req.item.z;
						is_dab_q  <= pend_room;
					end
				end
			end
			S_SUB: begin
				sp_q <= sp_val;
				for (int i = 0; i < 3; i++) begin
					d_q[i]   <= d_nx[i];
					mag_q[i] <= d_nx[i][DIFF_W-1] ? MAG_W'(-d_nx[i]) : MAG_W'(d_nx[i]);
				end
			end
			S_SQ: begin
			end
			S_SUM: begin
			end
			S_ROOT: begin
				if (sqrt_done) dist_q <= sqrt_root;
			end
			S_DIV: begin
				if (div_done[0]) begin
					t_q <= T_W'(sp_q);
					for (int i = 0; i < 3; i++) begin
						q0_q[i]  <= div_quot[i][SP_W-1:0];
						r0_q[i]  <= div_rem[i];
						acc_q[i] <= '0;
						rem_q[i] <= dist_q >> 1;
					end
					if (!pend_room) begin
						for (int i = 0; i < 3; i++) prev_q[i] <= cur_q[i];
					end
				end
			end
			S_STEP: begin
				t_q      <= t_nx;
				last_q   <= !more;
				is_dab_q <= 1'b1;
				for (int i = 0; i < 3; i++) begin
					acc_q[i] <= acc_nx[i];
					rem_q[i] <= rem_nx[i];
					pos_q[i] <= pos_nx[i][POS_W-1:0];
				end
				if (!more) begin
					for (int i = 0; i < 3; i++) prev_q[i] <= cur_q[i];
				end
			end
			S_BOX1: begin
				for (int i = 0; i < 3; i++) begin
					neg_q[i]     <= 1'b0;
					u_q[i]       <= v_lo[i][POS_W+1] ? '0 : v_lo[i][U_W-1:0];
					neg_q[3 + i] <= w_hi[i][POS_W+1];
					u_q[3 + i]   <= w_hi[i][POS_W+1] ? U_W'(-w_hi[i]) : (U_W'(w_hi[i]) + TS_M1);
				end
			end
			S_BOX2: begin
				for (int j = 0; j < 6; j++) tq_q[j] <= rprod[j][RECIP_SHIFT +: U_W];
			end
			S_BOX3: begin
				for (int i = 0; i < 3; i++) begin
					if (box_empty_q || bval[i] < box_q[i]) box_q[i] <= bval[i];
					if (box_empty_q || bval[3 + i] > box_q[3 + i]) box_q[3 + i] <= bval[3 + i];
				end
			end
			S_LOAD: begin
				olast_q <= last_q;
				if (is_dab_q) begin
					kind_q  <= KIND_DAB;
					opres_q <= pres_q;
					for (int i = 0; i < 3; i++) odab_q[i] <= pos_q[i];
				end else begin
					kind_q  <= box_empty_q ? KIND_EMPTY : KIND_BOX;
					opres_q <= '0;
					for (int i = 0; i < 3; i++) odab_q[i] <= '0;
				end
				for (int j = 0; j < 6; j++) obox_q[j] <= box_empty_q ? '0 : box_q[j];
			end
			default: begin
			end
		endcase
	end

	sdi_isqrt #(
		.RW(RAD_SUM_W)
	) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    (sq_sum),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// squares registered ahead of the root unit
	always_ff @(posedge clk) begin
		if (state_q == S_SQ) begin
			for (int i = 0; i < 3; i++) sq_q[i] <= SQ_W'(mag_q[i]) * SQ_W'(mag_q[i]);
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_div
		sdi_div #(
			.NW(NUM_W),
			.DW(DIST_W)
		) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (div_start),
			.num    (div_num[g]),
			.den    (dist_q),
			.done   (div_done[g]),
			.quot   (div_quot[g]),
			.rem    (div_rem[g])
		);
	end

	assign kind         = kind_q;
	assign dab_x        = odab_q[0];
	assign dab_y        = odab_q[1];
	assign dab_z        = odab_q[2];
	assign dab_pressure = opres_q;
	assign last         = olast_q;
	assign box_min_x    = obox_q[0];
	assign box_min_y    = obox_q[1];
	assign box_min_z    = obox_q[2];
	assign box_max_x    = obox_q[3];
	assign box_max_y    = obox_q[4];
	assign box_max_z    = obox_q[5];

	`SDI_ASSERT_ALWAYS(a_pend_cap, {1'b0, pend_q} <= LIMIT_C, "pending count above cap")
	`SDI_ASSERT_SAME(a_dab_box, out_valid && kind == KIND_DAB, !box_empty_q, "dab with empty box")
	`SDI_ASSERT_NEXT(a_more_dabs, out_valid && out_ready && !last, state_q == S_STEP, "dab run lost")

endmodule

`default_nettype wire

// ===== design/stroke_dab_interpolator.sv =====
// Stroke dab interpolator, top level: brush radius register, front end and back end.
// Depends on sdi_pkg, sdi_front and sdi_back.
//
// Turns brush stroke requests into dab results. A two-entry queue sits between the
// front end, which takes and decodes requests, and the back end, which runs them one
// at a time. A request other than a sample of an active stroke gives one status result
// through the load and emit states. A later sample of a stroke passes the subtract,
// square and sum states and the 22-step square root unit to reach the length check; a
// segment shorter than the spacing then gives its status result, otherwise the three
// bit-serial dividers find the per-axis step size and each dab then passes the step,
// box and load states, a further dab waiting for the output to take the last; the first
// sample of a stroke gives its dab through the box and load states. The radius is
// latched at stroke begin; write it only while the block is idle.
`default_nettype none

module stroke_dab_interpolator import sdi_pkg::*; #(
	parameter int TILE_SIZE     = TILE_SIZE_DEF,
	parameter int PENDING_LIMIT = PENDING_LIMIT_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [RAD_W-1:0]            cfg_wr_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [CMD_W-1:0]            cmd,
	input  wire logic signed [POS_W-1:0]     pos_x,
	input  wire logic signed [POS_W-1:0]     pos_y,
	input  wire logic signed [POS_W-1:0]     pos_z,
	input  wire logic signed [PRES_IN_W-1:0] pen_pressure,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [KIND_W-1:0]                kind,
	output logic signed [POS_W-1:0]          dab_x,
	output logic signed [POS_W-1:0]          dab_y,
	output logic signed [POS_W-1:0]          dab_z,
	output logic [PRES_W-1:0]                dab_pressure,
	output logic                             last,
	output logic signed [BOX_W-1:0]          box_min_x,
	output logic signed [BOX_W-1:0]          box_min_y,
	output logic signed [BOX_W-1:0]          box_min_z,
	output logic signed [BOX_W-1:0]          box_max_x,
	output logic signed [BOX_W-1:0]          box_max_y,
	output logic signed [BOX_W-1:0]          box_max_z
);

	logic [RAD_W-1:0] brush_radius_q;
	q_req_t           q_req;
	logic             q_ready;

	// brush radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brush_radius_q <= RAD_RESET;
		end else if (cfg_wr_en) begin
			brush_radius_q <= cfg_wr_data;
		end
	end

	sdi_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.pen_pressure (pen_pressure),
		.q_req        (q_req),
		.q_ready      (q_ready)
	);

	sdi_back #(
		.TILE_SIZE     (TILE_SIZE),
		.PENDING_LIMIT (PENDING_LIMIT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_req        (q_req),
		.q_ready      (q_ready),
		.brush_radius (brush_radius_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.dab_x        (dab_x),
		.dab_y        (dab_y),
		.dab_z        (dab_z),
		.dab_pressure (dab_pressure),
		.last         (last),
		.box_min_x    (box_min_x),
		.box_min_y    (box_min_y),
		.box_min_z    (box_min_z),
		.box_max_x    (box_max_x),
		.box_max_y    (box_max_y),
		.box_max_z    (box_max_z)
	);

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for the stroke dab interpolator: directed and random stroke requests.
// Depends on sdi_pkg and the stroke_dab_interpolator RTL; a dab scoreboard predicts results.
`timescale 1ns / 100ps

module testbench;
	import sdi_pkg::*;

	localparam int CLK_HALF   = 2;
	localparam int LIMIT      = 3000000;
	localparam int TILE       = 8;
	localparam int PEND_CAP   = 64;
	localparam int SETTLE     = 16;
	localparam logic [CMD_W-1:0] CMD_BAD_LO  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_BAD_MID = 3'd6;
	localparam logic [CMD_W-1:0] CMD_BAD_HI  = 3'd7;
	localparam int POS_MAX = 1048575;
	localparam int POS_MIN = -1048576;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [POS_W-1:0]  z;
		logic [PRES_W-1:0] pres;
		logic              last;
		logic [BOX_W-1:0]  box [6];
	} dab_res_t;

	// predicts dab and status results and checks them in order
	class dab_scoreboard;
		bit      active;
		bit      have_prev;
		longint  prev [3];
		int      pending;
		bit      box_empty;
		longint  box [6];
		int      radius;
		int      stroke_rad;
		int      errors;
		dab_res_t expected [$];

		function new();
			active = 0;
			have_prev = 0;
			prev = '{0, 0, 0};
			pending = 0;
			clear_box();
			radius = 256;
			stroke_rad = 256;
			errors = 0;
		endfunction

		function void clear_box();
			box_empty = 1;
			box = '{0, 0, 0, 0, 0, 0};
		endfunction

		function void set_radius(int r);
			radius = r;
		endfunction

		function int outstanding();
			return expected.size();
		endfunction

		function longint floor_div(longint a, longint b);
			longint q;
			q = a / b;
			if (a % b != 0 && a < 0) q--;
			return q;
		endfunction

		function longint ceil_div(longint a, longint b);
			longint q;
			q = a / b;
			if (a % b != 0 && a > 0) q++;
			return q;
		endfunction

		function longint int_sqrt(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return longint'(r);
		endfunction

		function longint round_div(longint num, longint den);
			longint an, q;
			an = num < 0 ? -num : num;
			q = (an + den / 2) / den;
			return num < 0 ? -q : q;
		endfunction

		function void grow_box(longint c [3]);
			longint lo, hi;
			for (int i = 0; i < 3; i++) begin
				lo = floor_div(floor_div(c[i] - stroke_rad, 256), TILE) * TILE;
				hi = ceil_div(ceil_div(c[i] + stroke_rad, 256), TILE) * TILE;
				if (lo < 0) lo = 0;
				if (box_empty || lo < box[i]) box[i] = lo;
				if (box_empty || hi > box[3 + i]) box[3 + i] = hi;
			end
			box_empty = 0;
		endfunction

		function void push_res(logic [KIND_W-1:0] k, longint c [3], int pr);
			dab_res_t r;
			r.kind = k;
			r.x = c[0][POS_W-1:0];
			r.y = c[1][POS_W-1:0];
			r.z = c[2][POS_W-1:0];
			r.pres = pr[PRES_W-1:0];
			r.last = 0;
			for (int i = 0; i < 6; i++)
				r.box[i] = box_empty ? '0 : box[i][BOX_W-1:0];
			expected.push_back(r);
		endfunction

		// accepted request: work out every result it causes
		function void note_request(logic [CMD_W-1:0] c, logic signed [POS_W-1:0] px,
				logic signed [POS_W-1:0] py, logic signed [POS_W-1:0] pz,
				logic signed [PRES_IN_W-1:0] pp);
			longint p [3], d [3], e [3], zero [3];
			longint sp, seg_len, t;
			longint unsigned sq;
			int pr, n;
			p = '{px, py, pz};
			zero = '{0, 0, 0};
			pr = pp < 0 ? 0 : (pp > 256 ? 256 : int'(pp));
			n = 0;
			if (c == CMD_BEGIN) begin
				stroke_rad = radius;
				active = 1;
				have_prev = 0;
				pending = 0;
				clear_box();
			end else if (c == CMD_SAMPLE && active) begin
				if (!have_prev) begin
					if (pending < PEND_CAP) begin
						pending++;
						grow_box(p);
						push_res(KIND_DAB, p, pr);
						n = 1;
					end
					prev = p;
					have_prev = 1;
				end else begin
					sp = (longint'(stroke_rad) * 90) / 256;
					for (int i = 0; i < 3; i++) d[i] = p[i] - prev[i];
					sq = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
					seg_len = int_sqrt(sq);
					if (sp < 256) sp = 256;
					if (seg_len >= sp) begin
						for (t = sp; t <= seg_len && pending < PEND_CAP; t += sp) begin
							for (int i = 0; i < 3; i++)
								e[i] = prev[i] + round_div(d[i] * t, seg_len);
							pending++;
							grow_box(e);
							push_res(KIND_DAB, e, pr);
							n++;
						end
						prev = p;
					end
				end
			end else if (c == CMD_END) begin
				active = 0;
				have_prev = 0;
			end else if (c == CMD_CLEAR) begin
				pending = 0;
				clear_box();
			end else if (c == CMD_RESET) begin
				pending = 0;
				clear_box();
				active = 0;
				have_prev = 0;
			end
			if (n == 0) push_res(box_empty ? KIND_EMPTY : KIND_BOX, zero, 0);
			expected[$].last = 1;
		endfunction

		function void cmp(string name, longint unsigned exp_v, longint unsigned got_v);
			if (exp_v != got_v) begin
				$error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
				errors++;
			end
		endfunction

		// accepted result against the oldest expectation
		function void check_result(dab_res_t got);
			dab_res_t w;
			if (expected.size() == 0) begin
				$error("result with nothing expected: kind %0d", got.kind);
				errors++;
				return;
			end
			w = expected.pop_front();
			cmp("kind", w.kind, got.kind);
			cmp("dab_x", w.x, got.x);
			cmp("dab_y", w.y, got.y);
			cmp("dab_z", w.z, got.z);
			cmp("dab_pressure", w.pres, got.pres);
			cmp("last", w.last, got.last);
			cmp("box_min_x", w.box[0], got.box[0]);
			cmp("box_min_y", w.box[1], got.box[1]);
			cmp("box_min_z", w.box[2], got.box[2]);
			cmp("box_max_x", w.box[3], got.box[3]);
			cmp("box_max_y", w.box[4], got.box[4]);
			cmp("box_max_z", w.box[5], got.box[5]);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [RAD_W-1:0] cfg_wr_data;
	logic in_valid, in_ready;
	logic [CMD_W-1:0] cmd;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic signed [PRES_IN_W-1:0] pen_pressure;
	logic out_valid, out_ready;
	logic [KIND_W-1:0] kind;
	logic signed [POS_W-1:0] dab_x, dab_y, dab_z;
	logic [PRES_W-1:0] dab_pressure;
	logic last;
	logic signed [BOX_W-1:0] box_min_x, box_min_y, box_min_z;
	logic signed [BOX_W-1:0] box_max_x, box_max_y, box_max_z;

	dab_scoreboard sb;
	int  cycles;
	bit  hold_req;
	int  burst_left;
	longint cur [3];

	stroke_dab_interpolator u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.pen_pressure(pen_pressure),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .dab_x(dab_x), .dab_y(dab_y), .dab_z(dab_z),
		.dab_pressure(dab_pressure), .last(last),
		.box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
		.box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z)
	);

	initial begin
		clk = 0;
		forever #CLK_HALF clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// result monitor
	always @(posedge clk) begin
		dab_res_t r;
		if (arst_n && out_valid && out_ready) begin
			r.kind = kind;
			r.x = dab_x;
			r.y = dab_y;
			r.z = dab_z;
			r.pres = dab_pressure;
			r.last = last;
			r.box = '{box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z};
			sb.check_result(r);
		end
	end

	// receiver stalls: a new random pattern from time to time, long hold-off on request
	initial begin
		int mode, hold;
		out_ready = 0;
		mode = 0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (cycles % 64 == 0) mode = $urandom_range(0, 3);
			if (hold_req && hold == 0) hold = 400;
			if (hold > 0) begin
				hold--;
				if (hold == 0) hold_req = 0;
				out_ready = 0;
			end else begin
				case (mode)
					0: out_ready = 1;
					1: out_ready = $urandom_range(0, 1);
					2: out_ready = (cycles % 4 == 0);
					default: out_ready = ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// one request; valid stays up across a burst, may drop for a random gap after it
	task automatic send_req(logic [CMD_W-1:0] c, longint x, longint y, longint z,
			logic signed [PRES_IN_W-1:0] p);
		@(negedge clk);
		in_valid = 1;
		cmd = c;
		pos_x = x[POS_W-1:0];
		pos_y = y[POS_W-1:0];
		pos_z = z[POS_W-1:0];
		pen_pressure = p;
		do @(posedge clk); while (!in_ready);
		sb.note_request(c, pos_x, pos_y, pos_z, pen_pressure);
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				@(negedge clk);
				in_valid = 0;
				repeat ($urandom_range(0, 8)) @(negedge clk);
			end
		end
	endtask

	task automatic drain_and_idle();
		@(negedge clk);
		in_valid = 0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_radius(logic [RAD_W-1:0] r);
		@(negedge clk);
		cfg_wr_en = 1;
		cfg_wr_data = r;
		@(negedge clk);
		cfg_wr_en = 0;
		sb.set_radius(r);
	endtask

	function automatic longint clamp_pos(longint v);
		return v > POS_MAX ? POS_MAX : (v < POS_MIN ? POS_MIN : v);
	endfunction

	function automatic longint rand_pos();
		return longint'($urandom_range(0, 2097151)) + POS_MIN;
	endfunction

	function automatic logic signed [PRES_IN_W-1:0] rand_pres();
		return PRES_IN_W'($urandom);
	endfunction

	// random stroke: begin, walk with small steps, usually end or reset; some noise in between
	task automatic random_stroke(int max_step);
		int n;
		send_req(CMD_BEGIN, rand_pos(), rand_pos(), rand_pos(), rand_pres());
		if ($urandom_range(0, 4) == 0) begin
			for (int i = 0; i < 3; i++) cur[i] = rand_pos();
		end else begin
			for (int i = 0; i < 3; i++) cur[i] = $signed($urandom_range(0, 8192)) - 4096;
		end
		n = $urandom_range(2, 8);
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 19))
				0: send_req(CMD_CLEAR, rand_pos(), rand_pos(), rand_pos(), rand_pres());
				1: send_req(CMD_W'(CMD_BAD_LO + $urandom_range(0, 2)), rand_pos(), rand_pos(),
					rand_pos(), rand_pres());
				2: begin
					for (int i = 0; i < 3; i++) cur[i] = rand_pos();
					send_req(CMD_SAMPLE, cur[0], cur[1], cur[2], rand_pres());
				end
				default: begin
					for (int i = 0; i < 3; i++)
						cur[i] = clamp_pos(cur[i] + $signed($urandom_range(0, 2 * max_step))
							- max_step);
					send_req(CMD_SAMPLE, cur[0], cur[1], cur[2], rand_pres());
				end
			endcase
		end
		case ($urandom_range(0, 5))
			0: send_req(CMD_RESET, rand_pos(), rand_pos(), rand_pos(), rand_pres());
			1: ;
			default: send_req(CMD_END, rand_pos(), rand_pos(), rand_pos(), rand_pres());
		endcase
		if ($urandom_range(0, 3) == 0)
			send_req(CMD_SAMPLE, rand_pos(), rand_pos(), rand_pos(), rand_pres());
	endtask

	initial begin
		logic [RAD_W-1:0] radii [4];
		int steps [4];
		sb = new();
		cycles = 0;
		hold_req = 0;
		burst_left = 1;
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_wr_data = '0;
		in_valid = 0;
		cmd = CMD_BEGIN;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		pen_pressure = '0;
		repeat (10) @(negedge clk);
		arst_n = 1;
		repeat (4) @(negedge clk);

		// directed: reset radius, pressure clamps, short segments, odd commands
		send_req(CMD_SAMPLE, 0, 0, 0, 0);
		send_req(CMD_BEGIN, 0, 0, 0, 0);
		send_req(CMD_SAMPLE, 1280, -700, 300, -10'sd512);
		send_req(CMD_SAMPLE, 1400, -700, 300, 10'sd511);
		send_req(CMD_SAMPLE, 2300, 900, -256, 10'sd256);
		send_req(CMD_SAMPLE, 2300, 900, -256, 10'sd257);
		send_req(CMD_SAMPLE, POS_MAX, POS_MAX, POS_MAX, 10'sd100);
		send_req(CMD_SAMPLE, POS_MIN, POS_MIN, POS_MIN, -10'sd1);
		send_req(CMD_CLEAR, 0, 0, 0, 0);
		send_req(CMD_SAMPLE, POS_MIN, POS_MAX, 0, 10'sd128);
		send_req(CMD_END, 0, 0, 0, 0);
		send_req(CMD_SAMPLE, 500, 500, 500, 10'sd200);
		send_req(CMD_BAD_LO, POS_MAX, POS_MIN, POS_MAX, 10'sd511);
		send_req(CMD_BAD_MID, 0, 0, 0, 0);
		send_req(CMD_BAD_HI, POS_MIN, POS_MAX, POS_MIN, -10'sd512);
		send_req(CMD_BEGIN, 0, 0, 0, 0);
		send_req(CMD_SAMPLE, -3000, 4000, -5000, 10'sd64);
		send_req(CMD_RESET, 0, 0, 0, 0);
		send_req(CMD_SAMPLE, 0, 0, 0, 10'sd64);
		send_req(CMD_END, 0, 0, 0, 0);
		drain_and_idle();

		// random phases over several radius settings, extremes included
		radii = '{16'd0, 16'd65535, 16'd700, 16'($urandom)};
		steps = '{2000, 40000, 4000, 8000};
		for (int ph = 0; ph < 4; ph++) begin
			write_radius(radii[ph]);
			if (ph == 1) hold_req = 1;
			for (int s = 0; s < 12; s++) random_stroke(steps[ph]);
			drain_and_idle();
		end

		if (sb.errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
